>>> rtl/swa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sliding window average block
// no dependencies

package swa_pkg;

	localparam int SAMPLE_W = 32;                      // q16.16 sample and average
	localparam int CNT_W    = 9;                       // window size and fill count
	localparam int SUM_W    = SAMPLE_W + CNT_W;        // exact sum of up to 511 samples

	// divider: magnitude of the sum, DIV_STEP quotient bits per cycle
	localparam int DIV_STEP    = 4;
	localparam int DIV_STEPS   = (SUM_W + DIV_STEP - 1) / DIV_STEP;
	localparam int MAG_W       = DIV_STEPS * DIV_STEP;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RMW,
		S_LOAD,
		S_DIV
	} swa_state_t;

	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] quotient;
	} div_res_t;

endpackage

>>> rtl/swa_in_if.sv
`timescale 1ns / 1ps
// input channel: one q16.16 sample per beat
// depends on swa_pkg

interface swa_in_if import swa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/swa_out_if.sv
`timescale 1ns / 1ps
// result channel: average, count and full flag per beat
// depends on swa_pkg

interface swa_out_if import swa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] average;
	logic [CNT_W-1:0]           sample_count;
	logic                       window_full;

	modport source (output valid, output average, output sample_count,
		output window_full, input ready);
	modport sink (input valid, input average, input sample_count,
		input window_full, output ready);
endinterface

>>> rtl/swa_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies

module swa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/swa_div.sv
`timescale 1ns / 1ps
// signed sum by unsigned count divider, truncating toward zero
// restoring, DIV_STEP quotient bits per cycle; depends on swa_pkg

module swa_div import swa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	input  logic                    ack,
	output div_res_t                res
);

	logic                 busy_q;
	logic                 valid_q;
	logic                 neg_q;
	logic [MAG_W-1:0]     num_q;
	logic [CNT_W:0]       rem_q;
	logic [CNT_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] step_q;

	logic [SUM_W-1:0]     mag;
	logic [MAG_W-1:0]     num_d;
	logic [CNT_W:0]       rem_d;
	logic [SAMPLE_W-1:0]  quot_mag;

	// magnitude of the dividend
	always_comb begin
		if (dividend[SUM_W-1]) begin
			mag = SUM_W'(-dividend);
		end else begin
			mag = SUM_W'(dividend);
		end
	end

	// one cycle of restoring steps; the numerator shifts out, quotient bits shift in
	always_comb begin
		num_d = num_q;
		rem_d = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			rem_d = {rem_d[CNT_W-1:0], num_d[MAG_W-1]};
			num_d = {num_d[MAG_W-2:0], 1'b0};
			if (rem_d >= {1'b0, den_q}) begin
				rem_d    = rem_d - {1'b0, den_q};
				num_d[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (start) begin
				busy_q  <= 1'b1;
				valid_q <= 1'b0;
				step_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				step_q <= step_q - DIV_CNT_W'(1);
				if (step_q == '0) begin
					busy_q  <= 1'b0;
					valid_q <= 1'b1;
				end
			end else if (ack) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			num_q <= MAG_W'(mag);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	// quotient magnitude is at most 2^31, so the low word carries it
	assign quot_mag = num_q[SAMPLE_W-1:0];

	always_comb begin
		res.valid = valid_q;
		if (neg_q) begin
			res.quotient = $signed(-quot_mag);
		end else begin
			res.quotient = $signed(quot_mag);
		end
	end

endmodule

>>> rtl/sliding_window_average.sv
`timescale 1ns / 1ps
// top level of the sliding window average block
// depends on swa_pkg, swa_in_if, swa_out_if, swa_ram, swa_div

// Sliding window average over signed q16.16 samples. Each accepted sample beat
// yields one result beat: the mean of the most recent window_size samples
// (the exact running sum divided by the count, truncated toward zero), the
// number of samples now held, and a flag that is set once the window is full.
// Samples live in a ring held in one synchronous ram of MAX_WINDOW words.
// While the ring fills, a sample is appended at the fill count; once it is
// full, the oldest entry is read, taken off the sum and overwritten in place.
// Writing window_size (0 acts as 1, values above MAX_WINDOW saturate) restarts
// filling; write it only while no result is outstanding. After acceptance an
// item passes through S_RMW, which updates sum and ring (the oldest entry is
// read at acceptance), S_LOAD, which launches the divide, and S_DIV, where the
// divider retires four quotient bits per cycle over a 44-bit magnitude and the
// result then waits to be loaded into the output register. The next sample is
// accepted once the result sits there, even while it still waits for the sink.

module sliding_window_average import swa_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             window_size_we,
	input  logic [CNT_W-1:0] window_size,
	swa_in_if.sink           sample_ch,
	swa_out_if.source        result_ch
);

	localparam int AW        = $clog2(MAX_WINDOW);
	localparam int WIN_RESET = (MAX_WINDOW < 256) ? MAX_WINDOW : 256;

	// control state
	swa_state_t state_q, state_d;
	logic [CNT_W-1:0]       wsize_q;       // clamped window size
	logic [CNT_W-1:0]       fill_count_q;
	logic [AW-1:0]          pos_q;         // oldest entry once the ring is full
	logic signed [SUM_W-1:0] sum_q;
	logic                   out_valid_q;

	// item in flight
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       full_s1;

	// output payload
	logic signed [SAMPLE_W-1:0] average_q;
	logic [CNT_W-1:0]           count_q;
	logic                       out_full_q;

	// fsm outputs
	logic in_ready;
	logic rmw;
	logic div_start;
	logic out_load;

	logic [CNT_W-1:0]        wsize_clamped;
	logic                    filling;
	logic                    accept;
	logic [SAMPLE_W-1:0]     rd_data;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] sum_next;
	logic [AW-1:0]           wr_addr;
	logic                    pos_wrap;
	div_res_t                div_res;

	// written window size, clamped to 1..MAX_WINDOW
	always_comb begin
		if (window_size == '0) begin
			wsize_clamped = CNT_W'(1);
		end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
			wsize_clamped = CNT_W'(MAX_WINDOW);
		end else begin
			wsize_clamped = window_size;
		end
	end

	assign filling = fill_count_q < wsize_q;
	assign accept  = sample_ch.valid && in_ready;
	assign sample_ch.ready = in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample_ch.valid) begin
					state_d = S_RMW;
				end
			end
			S_RMW: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		in_ready  = 1'b0;
		rmw       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_RMW: begin
				rmw = 1'b1;
			end
			S_LOAD: begin
				div_start = 1'b1;
			end
			S_DIV: begin
				// result register is free or drains this cycle
				out_load = div_res.valid && (!out_valid_q || result_ch.ready);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// ring store; the oldest entry is read only when the ring is full
	assign wr_addr = full_s1 ? pos_q : AW'(fill_count_q);

	swa_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (rmw),
		.waddr (wr_addr),
		.wdata (sample_s1),
		.re    (accept && !filling),
		.raddr (pos_q),
		.rdata (rd_data)
	);

	// sum update: drop the evicted sample, add the new one
	always_comb begin
		if (full_s1) begin
			old_ext = SUM_W'($signed(rd_data));
		end else begin
			old_ext = '0;
		end
		new_ext  = SUM_W'(sample_s1);
		sum_next = sum_q - old_ext + new_ext;
	end

	assign pos_wrap = (32'(pos_q) + 32'd1) >= 32'(wsize_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wsize_q      <= CNT_W'(WIN_RESET);
			fill_count_q <= '0;
			pos_q        <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (window_size_we) begin
				// restart filling
				wsize_q      <= wsize_clamped;
				fill_count_q <= '0;
				pos_q        <= '0;
				sum_q        <= '0;
			end else if (rmw) begin
				sum_q <= sum_next;
				if (full_s1) begin
					pos_q <= pos_wrap ? '0 : pos_q + AW'(1);
				end else begin
					fill_count_q <= fill_count_q + CNT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_ch.sample;
			full_s1   <= !filling;
		end
		if (out_load) begin
			average_q  <= div_res.quotient;
			count_q    <= fill_count_q;
			out_full_q <= fill_count_q == wsize_q;
		end
	end

	swa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_count_q),
		.ack      (out_load),
		.res      (div_res)
	);

	assign result_ch.valid        = out_valid_q;
	assign result_ch.average      = average_q;
	assign result_ch.sample_count = count_q;
	assign result_ch.window_full  = out_full_q;

endmodule

>>> tb/swa_mean_checker.sv
`timescale 1ns / 1ps
// result checker for the sliding window average block: tracks window_size
// writes and sample beats, predicts each result beat and compares it
// depends on swa_pkg, swa_in_if, swa_out_if

module swa_mean_checker import swa_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             window_size_we,
	input  logic [CNT_W-1:0] window_size,
	swa_in_if                sample_mon,
	swa_out_if               result_mon,
	output int unsigned      fail_count
);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic [CNT_W-1:0]           sample_count;
		logic                       window_full;
	} mean_beat_t;

	localparam int REPORT_MAX = 100;

	logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
	int unsigned win_len;
	int unsigned fill;
	int unsigned oldest;
	longint      sum;
	mean_beat_t  expected_means [$];
	int unsigned n_bad;
	int unsigned n_waiting;

	// beats still waiting at the end count as failures too
	assign fail_count = n_bad + n_waiting;

	function automatic int unsigned clamp_window(logic [CNT_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_WINDOW)
			return MAX_WINDOW;
		return v;
	endfunction

	function automatic void restart_window(logic [CNT_W-1:0] v);
		win_len = clamp_window(v);
		fill    = 0;
		oldest  = 0;
		sum     = 0;
	endfunction

	// append while filling, replace the oldest entry once full
	function automatic mean_beat_t take_sample(logic signed [SAMPLE_W-1:0] v);
		mean_beat_t r;
		longint     q;
		if (fill < win_len) begin
			ring[fill] = v;
			fill++;
			sum += v;
		end else begin
			if (oldest >= win_len)
				oldest = 0;
			sum -= ring[oldest];
			ring[oldest] = v;
			sum += v;
			oldest = (oldest + 1 >= win_len) ? 0 : oldest + 1;
		end
		q = sum / longint'(fill);
		r.average      = q[SAMPLE_W-1:0];
		r.sample_count = fill[CNT_W-1:0];
		r.window_full  = (fill == win_len);
		return r;
	endfunction

	function automatic void note_bad(string field, logic [SAMPLE_W-1:0] want,
		logic [SAMPLE_W-1:0] got);
		if (n_bad < REPORT_MAX)
			$error("%s: expected 0x%h, got 0x%h", field, want, got);
		n_bad++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mean_beat_t want;
		if (!arst_n) begin
			// window size after reset
			restart_window(CNT_W'(256));
			expected_means.delete();
			n_waiting = 0;
			n_bad     = 0;
		end else begin
			if (window_size_we)
				restart_window(window_size);
			if (sample_mon.valid && sample_mon.ready) begin
				expected_means.push_back(take_sample(sample_mon.sample));
				n_waiting++;
			end
			if (result_mon.valid && result_mon.ready) begin
				if (expected_means.size() == 0) begin
					if (n_bad < REPORT_MAX)
						$error("result beat with no sample waiting for it");
					n_bad++;
				end else begin
					want = expected_means.pop_front();
					n_waiting--;
					if (result_mon.average !== want.average)
						note_bad("average", want.average, result_mon.average);
					if (result_mon.sample_count !== want.sample_count)
						note_bad("sample_count", want.sample_count, result_mon.sample_count);
					if (result_mon.window_full !== want.window_full)
						note_bad("window_full", want.window_full, result_mon.window_full);
				end
			end
		end
	end

endmodule

>>> tb/tb_sliding_window_average.sv
`timescale 1ns / 1ps
// testbench top for the sliding window average block: drives sample beats,
// window_size writes and result backpressure, and gives the verdict
// depends on swa_pkg, swa_in_if, swa_out_if, sliding_window_average, swa_mean_checker

module tb_sliding_window_average;
	import swa_pkg::*;

	localparam int MAX_WINDOW   = 256;
	localparam int RANDOM_ITEMS = 1900;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

	// how the samples of one random phase are drawn
	typedef enum logic [1:0] {
		MIX_FULL,     // full range with extremes and small values mixed in
		PIN_MIN,      // mostly the most negative value
		PIN_MAX,      // mostly the most positive value
		SMALL_STEPS   // small values around zero, exercises truncation
	} fill_style_t;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             window_size_we;
	logic [CNT_W-1:0] window_size;
	int unsigned      fail_count;

	int unsigned n_sent = 0;       // sample beats accepted
	int unsigned n_rcvd = 0;       // result beats accepted
	bit          quiet  = 1'b0;    // no gaps and no stalls in the current phase
	int unsigned stall_left;

	swa_in_if  sample_ch ();
	swa_out_if result_ch ();

	always #2 clk = ~clk;

	sliding_window_average #(
		.MAX_WINDOW(MAX_WINDOW)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_size_we (window_size_we),
		.window_size    (window_size),
		.sample_ch      (sample_ch),
		.result_ch      (result_ch)
	);

	swa_mean_checker #(
		.MAX_WINDOW(MAX_WINDOW)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_size_we (window_size_we),
		.window_size    (window_size),
		.sample_mon     (sample_ch),
		.result_mon     (result_ch),
		.fail_count     (fail_count)
	);

	// idle length: mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_style_t style);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (style)
			PIN_MIN: begin
				return (r < 90) ? SAMPLE_MIN : $urandom;
			end
			PIN_MAX: begin
				return (r < 90) ? SAMPLE_MAX : $urandom;
			end
			SMALL_STEPS: begin
				return int'($urandom_range(0, 16)) - 8;
			end
			default: begin
				if (r < 10)
					return SAMPLE_MIN;
				if (r < 20)
					return SAMPLE_MAX;
				if (r < 30)
					return int'($urandom_range(0, 16)) - 8;
				return $urandom;
			end
		endcase
	endfunction

	// raw window_size value for a phase, including 0 and values above MAX_WINDOW
	function automatic int unsigned pick_window();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return MAX_WINDOW;
		if (r < 12)
			return 511;
		if (r < 15)
			return $urandom_range(MAX_WINDOW + 1, 510);
		if (r < 18)
			return 0;
		if (r < 26)
			return 1;
		if (r < 36)
			return $urandom_range(2, 4);
		if (r < 44)
			return $urandom_range(200, MAX_WINDOW - 1);
		return $urandom_range(1, 48);
	endfunction

	// one sample beat; called and returning at a rising edge, so valid is either
	// kept high or lowered at that edge, never both
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= v;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		n_sent++;
	endtask

	// stop sending and wait until every result beat has been taken
	task automatic settle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_rcvd != n_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// restart the window; only called once the block is idle
	task automatic set_window(input logic [CNT_W-1:0] v);
		window_size_we <= 1'b1;
		window_size    <= v;
		@(posedge clk);
		window_size_we <= 1'b0;
	endtask

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk)
		if (arst_n && result_ch.valid && result_ch.ready)
			n_rcvd <= n_rcvd + 1;

	initial begin
		int unsigned done_items;
		int unsigned n_phase;
		int unsigned raw_win;
		int unsigned eff_win;
		fill_style_t style;

		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready  = 1'b0;
		window_size_we   = 1'b0;
		window_size      = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of MAX_WINDOW, extremes while filling
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(-1);
		send_sample(1);
		send_sample(0);
		settle();

		// window size zero acts as one: every average is the sample itself
		set_window(9'd0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(-1);
		settle();

		// window of two: extreme averages, then -1.5 truncated toward zero
		set_window(9'd2);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(-1);
		send_sample(-2);
		settle();

		// sizes above MAX_WINDOW saturate, all-ones value included
		set_window(9'd511);
		send_sample(SAMPLE_MIN);
		send_sample(3);
		send_sample(SAMPLE_MAX);
		settle();
		set_window(9'd300);
		send_sample(-7);
		send_sample(2);
		settle();
		set_window(9'd257);
		send_sample(SAMPLE_MAX);
		settle();

		// random phases: each restarts the window, mostly fills and wraps it,
		// sometimes restarts again mid-fill
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			raw_win = pick_window();
			eff_win = (raw_win == 0) ? 1 : (raw_win > MAX_WINDOW) ? MAX_WINDOW : raw_win;
			case ($urandom_range(0, 9))
				0:       style = PIN_MIN;
				1:       style = PIN_MAX;
				2:       style = SMALL_STEPS;
				default: style = MIX_FULL;
			endcase
			if ($urandom_range(0, 4) == 0)
				n_phase = $urandom_range(1, eff_win);
			else
				n_phase = eff_win + $urandom_range(1, eff_win + 8);
			// last phase stops at the item budget
			if (n_phase > RANDOM_ITEMS - done_items)
				n_phase = RANDOM_ITEMS - done_items;
			quiet = ($urandom_range(0, 3) == 0);
			set_window(raw_win[CNT_W-1:0]);
			repeat (n_phase)
				send_sample(pick_sample(style));
			done_items += n_phase;
			settle();
		end

		quiet = 1'b0;
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_sliding_window_average: PASS");
		else
			$display("tb_sliding_window_average: FAIL");
		$finish;
	end

	// far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("tb_sliding_window_average: FAIL");
		$finish;
	end

endmodule
